[rtl/slsu_pkg.sv]
// Shared types and constants for the sequential list store unit.
package slsu_pkg;

    localparam int KEY_W = 32;

    // Operation codes on the cmd field
    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Update select for one storage cell
    typedef struct packed {
        logic load_key;
        logic take_left;
        logic take_right;
    } cell_ctl_t;

endpackage

[rtl/sequential_list_store_unit.sv]
// Top level of the sequential list store unit: a packed ordered list of 32-bit keys.
//
// The list lives in a row of CAPACITY cells, each holding one key. In the
// cycle an operation is transferred in, each cell compares its key with the
// incoming key and the match flags are registered; once the output register
// is free, the lowest match is located and the whole row shifts up (insert)
// or down (delete) at once, and the result is loaded into the output register.
// A new item is not taken until the one before it has been committed; a result
// that waits in the output register does not block the next transfer in, only
// the update of the item after it. No clearing pass is needed after reset:
// only entries below the count are ever read.
module sequential_list_store_unit
    import slsu_pkg::*;
#(
    parameter int    CAPACITY = 64,
    localparam int   CW       = $clog2(CAPACITY + 1),
    localparam int   IW       = $clog2(CAPACITY)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic signed [KEY_W-1:0] key,
    input  logic [CW-1:0]           position,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    status,
    output logic [IW-1:0]           found_index,
    output logic [CW-1:0]           entry_count
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    cmd_t                cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [CW-1:0]       pos_reg;
    logic [CAPACITY-1:0] match_reg;

    logic                out_valid_reg;
    logic                status_reg;
    logic                status_next;
    logic [IW-1:0]       index_reg;
    logic [IW-1:0]       index_next;

    logic                in_xfer;
    logic                out_free;
    logic                commit;
    logic                hit;
    logic [CAPACITY-1:0] from_first;
    logic [IW-1:0]       first_index;
    logic                ins_ok;
    logic                del_ok;

    logic [KEY_W-1:0]    entry   [CAPACITY];
    logic [CAPACITY-1:0] match;
    cell_ctl_t           ctl     [CAPACITY];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == ST_EXEC) && out_free;

    // Locate the first live match
    slsu_locate #(
        .N  (CAPACITY),
        .IW (IW)
    ) u_locate (
        .match      (match_reg),
        .hit        (hit),
        .from_first (from_first),
        .index      (first_index)
    );

    assign ins_ok = (cmd_reg == CMD_INSERT) && (count_reg != CW'(CAPACITY))
                    && (pos_reg <= count_reg);
    assign del_ok = (cmd_reg == CMD_DELETE) && hit;

    // Row of storage cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;
        logic             in_list;

        if (i == 0)
        begin : g_first
            assign left_key = key_reg;
        end
        else
        begin : g_mid
            assign left_key = entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = entry[i];
        end
        else
        begin : g_rest
            assign right_key = entry[i+1];
        end

        assign in_list = (CW'(i) < count_reg);

        // Insert writes the key at the position and moves later cells up
        assign ctl[i].load_key   = commit && ins_ok && (CW'(i) == pos_reg);
        assign ctl[i].take_left  = commit && ins_ok && (CW'(i) > pos_reg);
        // Delete moves cells from the first match onward down
        assign ctl[i].take_right = commit && del_ok && from_first[i];

        slsu_cell u_cell (
            .clk       (clk),
            .ctl       (ctl[i]),
            .new_key   (key_reg),
            .left_key  (left_key),
            .right_key (right_key),
            .cmp_key   (key),
            .in_list   (in_list),
            .entry     (entry[i]),
            .match     (match[i])
        );
    end

    // Work out the result and the new count
    always_comb
    begin
        status_next = 1'b0;
        index_next  = '0;
        count_next  = count_reg;
        case (cmd_reg)
            CMD_SEARCH:
            begin
                status_next = !hit;
                index_next  = hit ? first_index : '0;
            end
            CMD_INSERT:
            begin
                status_next = !ins_ok;
                if (ins_ok)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_DELETE:
            begin
                status_next = !del_ok;
                if (del_ok)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    // Sequence: take an item, then commit it when the output register is free
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item and the match flags on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg   <= cmd_t'(cmd);
            key_reg   <= key;
            pos_reg   <= position;
            match_reg <= match;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
        end
    end

    // The count register only moves on commit, so it holds the count of the waiting result
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = index_reg;
    assign entry_count = count_reg;

endmodule

[rtl/slsu_cell.sv]
// One storage cell of the list: holds a key, compares it and shifts with its neighbors.
module slsu_cell
    import slsu_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [KEY_W-1:0] new_key,
    input  logic [KEY_W-1:0] left_key,
    input  logic [KEY_W-1:0] right_key,
    input  logic [KEY_W-1:0] cmp_key,
    input  logic             in_list,
    output logic [KEY_W-1:0] entry,
    output logic             match
);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;

    // Pick the new content: the new key, left neighbor on insert, right neighbor on delete
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load_key)
        begin
            entry_next = new_key;
        end
        else if (ctl.take_left)
        begin
            entry_next = left_key;
        end
        else if (ctl.take_right)
        begin
            entry_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    // Only a live entry can match
    assign match = in_list && (entry_reg == cmp_key);

endmodule

[rtl/slsu_locate.sv]
// Lowest-match locator: one-hot of the first match, mask from it upward, and its index.
module slsu_locate #(
    parameter int N  = 64,
    parameter int IW = 6
) (
    input  logic [N-1:0]  match,
    output logic          hit,
    output logic [N-1:0]  from_first,
    output logic [IW-1:0] index
);

    logic [N-1:0] first_oh;

    // Isolate the lowest set bit
    assign first_oh   = match & (~match + N'(1));
    assign hit        = |match;
    // Bits at and above the first match
    assign from_first = ~(first_oh - N'(1));

    // Encode the one-hot position
    always_comb
    begin
        index = '0;
        for (int i = 0; i < N; i++)
        begin
            if (first_oh[i])
            begin
                index = index | IW'(i);
            end
        end
    end

endmodule

[verif/sequential_list_store_unit_test.sv]
// Testbench for the sequential list store unit: directed table, fill run and random run.
`timescale 1ns / 1ps

module sequential_list_store_unit_test;
    import slsu_pkg::*;

    localparam int DEPTH      = 64;
    localparam int RAND_OPS   = 520;
    localparam int CALM_OPS   = 80;
    localparam int MAX_CYCLES = 200000;

    typedef struct packed {
        logic       status;
        logic [5:0] index;
        logic [6:0] count;
    } list_result_t;

    typedef struct {
        cmd_t         op;
        logic [31:0]  k;
        logic [6:0]   pos;
        bit           typed;
        list_result_t want;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              cmd = CMD_SEARCH;
    logic signed [KEY_W-1:0] key = '0;
    logic [6:0]              position = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    status;
    logic [5:0]              found_index;
    logic [6:0]              entry_count;

    // Shadow copy of the list
    logic [31:0]  list_mem [DEPTH];
    int           list_len = 0;
    list_result_t pending_results [$];
    stim_row_t    dir_tab [$];
    logic [31:0]  key_pool [16];
    int           err_count = 0;
    int           cycles = 0;
    int           stall_left = 0;
    bit           calm = 1'b0;

    sequential_list_store_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .key        (key),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .found_index(found_index),
        .entry_count(entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        err_count++;
    endtask

    // Apply one operation to the shadow list and return its result
    function automatic list_result_t list_update(input cmd_t op, input logic [31:0] k,
                                                 input logic [6:0] pos);
        list_result_t r;
        int hit;
        r = '0;
        hit = -1;
        for (int p = 0; p < list_len; p++)
            if (hit < 0 && list_mem[p] == k)
                hit = p;
        case (op)
            CMD_SEARCH:
            begin
                if (hit >= 0)
                    r.index = hit[5:0];
                else
                    r.status = 1'b1;
            end
            CMD_INSERT:
            begin
                if (list_len >= DEPTH || int'(pos) > list_len)
                    r.status = 1'b1;
                else
                begin
                    for (int j = list_len; j > int'(pos); j--)
                        list_mem[j] = list_mem[j-1];
                    list_mem[pos] = k;
                    list_len++;
                end
            end
            CMD_DELETE:
            begin
                if (hit < 0)
                    r.status = 1'b1;
                else
                begin
                    for (int j = hit; j + 1 < list_len; j++)
                        list_mem[j] = list_mem[j+1];
                    list_len--;
                end
            end
            default:
                list_len = 0;
        endcase
        r.count = list_len[6:0];
        return r;
    endfunction

    function automatic stim_row_t row(input cmd_t op, input logic [31:0] k,
                                      input logic [6:0] pos, input bit typed,
                                      input logic st, input logic [5:0] idx,
                                      input logic [6:0] cnt);
        stim_row_t s;
        s.op = op;
        s.k = k;
        s.pos = pos;
        s.typed = typed;
        s.want = '{st, idx, cnt};
        return s;
    endfunction

    // Drive one transfer in, wait for it to be taken, then predict its result
    task automatic send_op(input stim_row_t s);
        list_result_t r;
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= s.op;
        key      <= s.k;
        position <= s.pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = list_update(s.op, s.k, s.pos);
        pending_results.push_back(s.typed ? s.want : r);
    endtask

    function automatic logic [31:0] pick_key(input bit want_hit);
        if (want_hit && list_len > 0)
            return list_mem[$urandom_range(0, list_len - 1)];
        if ($urandom_range(0, 2) != 0)
            return key_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // Check results and drive the output stall
    always @(posedge clk)
    begin
        list_result_t w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("result with nothing expected");
                else
                begin
                    w = pending_results.pop_front();
                    if (status !== w.status)
                        flag_mismatch($sformatf("status %b, want %b", status, w.status));
                    if (found_index !== w.index)
                        flag_mismatch($sformatf("found_index %0d, want %0d",
                                                found_index, w.index));
                    if (entry_count !== w.count)
                        flag_mismatch($sformatf("entry_count %0d, want %0d",
                                                entry_count, w.count));
                end
            end
            if (calm)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        stim_row_t s;
        int r;
        for (int i = 0; i < DEPTH; i++)
            list_mem[i] = '0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 16; i++)
            key_pool[i] = $urandom;

        // Directed table: empty list, extremes, duplicates, bad positions, clear
        dir_tab.push_back(row(CMD_SEARCH, 32'h0000_0000, 7'd0,   1, 1, 0, 0));
        dir_tab.push_back(row(CMD_DELETE, 32'h0000_0005, 7'd0,   1, 1, 0, 0));
        dir_tab.push_back(row(CMD_INSERT, 32'h0000_0001, 7'd1,   1, 1, 0, 0));
        dir_tab.push_back(row(CMD_INSERT, 32'h0000_0001, 7'd127, 1, 1, 0, 0));
        dir_tab.push_back(row(CMD_INSERT, 32'h8000_0000, 7'd0,   1, 0, 0, 1));
        dir_tab.push_back(row(CMD_INSERT, 32'h7FFF_FFFF, 7'd1,   1, 0, 0, 2));
        dir_tab.push_back(row(CMD_INSERT, 32'hFFFF_FFFF, 7'd0,   1, 0, 0, 3));
        dir_tab.push_back(row(CMD_INSERT, 32'h0000_0000, 7'd3,   1, 0, 0, 4));
        dir_tab.push_back(row(CMD_INSERT, 32'h7FFF_FFFF, 7'd2,   1, 0, 0, 5));
        dir_tab.push_back(row(CMD_SEARCH, 32'h7FFF_FFFF, 7'd99,  0, 0, 0, 0));
        dir_tab.push_back(row(CMD_SEARCH, 32'h0000_0000, 7'd0,   1, 0, 4, 5));
        dir_tab.push_back(row(CMD_SEARCH, 32'h0001_2345, 7'd0,   1, 1, 0, 5));
        dir_tab.push_back(row(CMD_DELETE, 32'h7FFF_FFFF, 7'd0,   0, 0, 0, 0));
        dir_tab.push_back(row(CMD_SEARCH, 32'h7FFF_FFFF, 7'd0,   0, 0, 0, 0));
        dir_tab.push_back(row(CMD_DELETE, 32'hFFFF_FFFF, 7'd0,   0, 0, 0, 0));
        dir_tab.push_back(row(CMD_DELETE, 32'h0BAD_0BAD, 7'd0,   0, 0, 0, 0));
        dir_tab.push_back(row(CMD_SEARCH, 32'h8000_0000, 7'd64,  0, 0, 0, 0));
        dir_tab.push_back(row(CMD_INSERT, 32'h0000_0007, 7'd5,   0, 0, 0, 0));
        dir_tab.push_back(row(CMD_CLEAR,  32'hFFFF_FFFF, 7'd127, 1, 0, 0, 0));
        dir_tab.push_back(row(CMD_SEARCH, 32'h8000_0000, 7'd0,   1, 1, 0, 0));
        dir_tab.push_back(row(CMD_CLEAR,  32'h0000_0000, 7'd0,   1, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_op(dir_tab[i]);

        // Fill to capacity, then push past it
        for (int i = 0; i < DEPTH; i++)
            send_op(row(CMD_INSERT, pick_key(0), 7'($urandom_range(0, list_len)), 0, 0, 0, 0));
        send_op(row(CMD_INSERT, pick_key(0), 7'd64, 0, 0, 0, 0));
        send_op(row(CMD_INSERT, pick_key(0), 7'd0, 0, 0, 0, 0));
        send_op(row(CMD_SEARCH, list_mem[DEPTH-1], 7'd0, 0, 0, 0, 0));
        send_op(row(CMD_DELETE, list_mem[DEPTH-1], 7'd0, 0, 0, 0, 0));

        // Random run: alternate growing and shrinking stretches
        for (int i = 0; i < RAND_OPS; i++)
        begin
            if (i >= RAND_OPS - CALM_OPS)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            if (((i / 120) % 2) == 0)
                s.op = (r < 2) ? CMD_CLEAR : (r < 57) ? CMD_INSERT :
                       (r < 77) ? CMD_SEARCH : CMD_DELETE;
            else
                s.op = (r < 2) ? CMD_CLEAR : (r < 22) ? CMD_INSERT :
                       (r < 47) ? CMD_SEARCH : CMD_DELETE;
            s.k = pick_key(s.op != CMD_INSERT && $urandom_range(0, 9) < 6);
            if ($urandom_range(0, 99) < 85)
                s.pos = 7'($urandom_range(0, list_len));
            else
                s.pos = 7'($urandom_range(0, 127));
            s.typed = 1'b0;
            s.want = '0;
            send_op(s);
        end
        in_valid <= 1'b0;
        calm = 1'b1;

        // Drain, then give stray results a chance to show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/slsu_pkg.sv
rtl/slsu_cell.sv
rtl/slsu_locate.sv
rtl/sequential_list_store_unit.sv
verif/sequential_list_store_unit_test.sv
